>>> rtl/core/lbm_pkg.sv
// Shared types and constants for the LRU block buffer manager.
// No dependencies; every other file in rtl/core refers to this package.
package lbm_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int AGE_BITS_DEF   = 16;
  localparam int BLOCK_W        = 16;
  localparam int SLOT_W         = 6;

  localparam logic [BLOCK_W-1:0] DISK_BLOCK_COUNT_RST = 16'd8192;

  typedef enum logic [1:0] {
    ACT_LOOKUP   = 2'd0,
    ACT_ALLOCATE = 2'd1,
    ACT_DIRTY    = 2'd2,
    ACT_FLUSH    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BOUND = 2'd1,
    ST_MISS  = 2'd2
  } status_t;

endpackage

>>> rtl/core/lru_block_buffer_manager.sv
// Top level of the LRU block buffer manager: bound register, slot memories and sequencer.
// Depends on lbm_pkg, lbm_slot_mem and lbm_scan_ctrl.
//
// An item is taken when start is high and busy is low. An item whose block number is at or
// above disk_block_count (flush excepted) is answered on the next cycle without going busy.
// Every other item walks the slot memories once, one slot read per cycle from a registered
// read port, and holds busy until it finishes with its final result. Results appear for
// one cycle on out_strobe and cannot be held off. A flush gives one result per dirty slot
// (a single result without writeback if none is dirty), spread over the scan, and the
// result with out_last set ends every item.
module lru_block_buffer_manager #(
  parameter int SLOT_COUNT = lbm_pkg::SLOT_COUNT_DEF,
  parameter int AGE_BITS   = lbm_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic [lbm_pkg::BLOCK_W-1:0] in_block_num,
  input  logic                        cfg_we,
  input  logic [lbm_pkg::BLOCK_W-1:0] cfg_wdata,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic [lbm_pkg::SLOT_W-1:0]  out_slot_index,
  output logic                        out_writeback,
  output logic [lbm_pkg::SLOT_W-1:0]  out_writeback_slot,
  output logic [lbm_pkg::BLOCK_W-1:0] out_writeback_block,
  output logic                        out_last
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic [lbm_pkg::BLOCK_W-1:0] disk_block_count_r;
  logic                        age_we;
  logic                        block_we;
  logic [IDX_W-1:0]            wr_addr;
  logic [AGE_BITS-1:0]         wr_age;
  logic [lbm_pkg::BLOCK_W-1:0] wr_block;
  logic [IDX_W-1:0]            rd_addr;
  logic [AGE_BITS-1:0]         rd_age;
  logic [lbm_pkg::BLOCK_W-1:0] rd_block;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_block_count_r <= lbm_pkg::DISK_BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      disk_block_count_r <= cfg_wdata;
    end
  end

  lbm_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .AGE_BITS   (AGE_BITS)
  ) u_mem (
    .clk      (clk),
    .age_we   (age_we),
    .block_we (block_we),
    .wr_addr  (wr_addr),
    .wr_age   (wr_age),
    .wr_block (wr_block),
    .rd_addr  (rd_addr),
    .rd_age   (rd_age),
    .rd_block (rd_block)
  );

  lbm_scan_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .AGE_BITS   (AGE_BITS)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_block_num        (in_block_num),
    .disk_block_count    (disk_block_count_r),
    .age_we              (age_we),
    .block_we            (block_we),
    .wr_addr             (wr_addr),
    .wr_age              (wr_age),
    .wr_block            (wr_block),
    .rd_addr             (rd_addr),
    .rd_age              (rd_age),
    .rd_block            (rd_block),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_writeback       (out_writeback),
    .out_writeback_slot  (out_writeback_slot),
    .out_writeback_block (out_writeback_block),
    .out_last            (out_last)
  );

endmodule

>>> rtl/core/lbm_slot_mem.sv
// Slot memories: per-slot age and held block number, one write and one read port each.
// Depends on lbm_pkg for the block number width and the default sizes.
module lbm_slot_mem #(
  parameter int SLOT_COUNT = lbm_pkg::SLOT_COUNT_DEF,
  parameter int AGE_BITS   = lbm_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                age_we,
  input  logic                                block_we,
  input  logic [$clog2(SLOT_COUNT)-1:0]       wr_addr,
  input  logic [AGE_BITS-1:0]                 wr_age,
  input  logic [lbm_pkg::BLOCK_W-1:0]         wr_block,
  input  logic [$clog2(SLOT_COUNT)-1:0]       rd_addr,
  output logic [AGE_BITS-1:0]                 rd_age,
  output logic [lbm_pkg::BLOCK_W-1:0]         rd_block
);

  logic [AGE_BITS-1:0]         age_mem   [SLOT_COUNT];
  logic [lbm_pkg::BLOCK_W-1:0] block_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[wr_addr] <= wr_age;
    end
    if (block_we) begin
      block_mem[wr_addr] <= wr_block;
    end
    rd_age   <= age_mem[rd_addr];
    rd_block <= block_mem[rd_addr];
  end

endmodule

>>> rtl/core/lbm_scan_ctrl.sv
// Request sequencer: scans the slot memories once per item past the bound check, keeps valid
// and dirty marks, and forms the result items. Depends on lbm_pkg.
module lbm_scan_ctrl #(
  parameter int SLOT_COUNT = lbm_pkg::SLOT_COUNT_DEF,
  parameter int AGE_BITS   = lbm_pkg::AGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [lbm_pkg::BLOCK_W-1:0]   in_block_num,
  input  logic [lbm_pkg::BLOCK_W-1:0]   disk_block_count,
  output logic                          age_we,
  output logic                          block_we,
  output logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  output logic [AGE_BITS-1:0]           wr_age,
  output logic [lbm_pkg::BLOCK_W-1:0]   wr_block,
  output logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  input  logic [AGE_BITS-1:0]           rd_age,
  input  logic [lbm_pkg::BLOCK_W-1:0]   rd_block,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic [lbm_pkg::SLOT_W-1:0]    out_slot_index,
  output logic                          out_writeback,
  output logic [lbm_pkg::SLOT_W-1:0]    out_writeback_slot,
  output logic [lbm_pkg::BLOCK_W-1:0]   out_writeback_block,
  output logic                          out_last
);

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int SLOT_W  = lbm_pkg::SLOT_W;
  localparam int BLOCK_W = lbm_pkg::BLOCK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                  state_r;
  lbm_pkg::action_t        act_r;
  logic [BLOCK_W-1:0]      blk_r;
  logic [IDX_W-1:0]        cnt_r;
  logic                    issue_done_r;
  logic                    d_v_r;
  logic [IDX_W-1:0]        d_idx_r;
  logic [SLOT_COUNT-1:0]   valid_r;
  logic [SLOT_COUNT-1:0]   dirty_r;
  logic                    found_r;
  logic [IDX_W-1:0]        found_idx_r;
  logic [AGE_BITS-1:0]     best_age_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [BLOCK_W-1:0]      best_blk_r;
  logic                    pend_v_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic [BLOCK_W-1:0]      pend_blk_r;

  logic                    strobe_r;
  lbm_pkg::status_t        status_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    wb_r;
  logic [SLOT_W-1:0]       wb_slot_r;
  logic [BLOCK_W-1:0]      wb_blk_r;
  logic                    last_r;

  logic                    cur_valid;
  logic                    cur_dirty;
  logic [AGE_BITS-1:0]     aged;
  logic [IDX_W-1:0]        victim;
  logic                    victim_wb;

  assign cur_valid = valid_r[d_idx_r];
  assign cur_dirty = dirty_r[d_idx_r];
  // Ages saturate at all ones; only occupied slots grow older.
  assign aged      = (cur_valid && !(&rd_age)) ? rd_age + 1'b1 : rd_age;
  // A free slot, when there is one, wins over the oldest slot and is never dirty.
  assign victim    = found_r ? found_idx_r : best_idx_r;
  assign victim_wb = !found_r && dirty_r[best_idx_r];

  assign rd_addr  = cnt_r;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    age_we   = 1'b0;
    block_we = 1'b0;
    wr_addr  = d_idx_r;
    wr_age   = aged;
    wr_block = blk_r;
    if (state_r == S_SCAN && d_v_r && act_r == lbm_pkg::ACT_ALLOCATE && cur_valid) begin
      age_we = 1'b1;
    end else if (state_r == S_DONE && act_r == lbm_pkg::ACT_ALLOCATE) begin
      age_we   = 1'b1;
      block_we = 1'b1;
      wr_addr  = victim;
      wr_age   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_done_r <= 1'b0;
      d_v_r        <= 1'b0;
      valid_r      <= '0;
      dirty_r      <= '0;
      found_r      <= 1'b0;
      pend_v_r     <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_action != lbm_pkg::ACT_FLUSH && in_block_num >= disk_block_count) begin
              strobe_r  <= 1'b1;
              status_r  <= lbm_pkg::ST_BOUND;
              slot_r    <= '0;
              wb_r      <= 1'b0;
              wb_slot_r <= '0;
              wb_blk_r  <= '0;
              last_r    <= 1'b1;
            end else begin
              state_r      <= S_SCAN;
              act_r        <= lbm_pkg::action_t'(in_action);
              blk_r        <= in_block_num;
              cnt_r        <= '0;
              issue_done_r <= 1'b0;
              d_v_r        <= 1'b0;
              found_r      <= 1'b0;
              pend_v_r     <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // Read issue: one slot address per cycle, data returns in the cycle after.
          if (!issue_done_r) begin
            d_v_r        <= 1'b1;
            d_idx_r      <= cnt_r;
            cnt_r        <= cnt_r + 1'b1;
            issue_done_r <= (cnt_r == LAST_IDX);
          end else begin
            d_v_r <= 1'b0;
          end
          if (d_v_r) begin
            case (act_r)
              lbm_pkg::ACT_LOOKUP, lbm_pkg::ACT_DIRTY: begin
                if (!found_r && cur_valid && rd_block == blk_r) begin
                  found_r     <= 1'b1;
                  found_idx_r <= d_idx_r;
                end
              end
              lbm_pkg::ACT_ALLOCATE: begin
                if (!found_r && !cur_valid) begin
                  found_r     <= 1'b1;
                  found_idx_r <= d_idx_r;
                end
                if (d_idx_r == '0 || aged > best_age_r) begin
                  best_age_r <= aged;
                  best_idx_r <= d_idx_r;
                  best_blk_r <= rd_block;
                end
              end
              lbm_pkg::ACT_FLUSH: begin
                // Each dirty slot is held back until the next dirty slot is found, so the final one can carry last.
                if (cur_valid && cur_dirty) begin
                  dirty_r[d_idx_r] <= 1'b0;
                  pend_v_r         <= 1'b1;
                  pend_idx_r       <= d_idx_r;
                  pend_blk_r       <= rd_block;
                  if (pend_v_r) begin
                    strobe_r  <= 1'b1;
                    status_r  <= lbm_pkg::ST_OK;
                    slot_r    <= SLOT_W'(pend_idx_r);
                    wb_r      <= 1'b1;
                    wb_slot_r <= SLOT_W'(pend_idx_r);
                    wb_blk_r  <= pend_blk_r;
                    last_r    <= 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
            if (d_idx_r == LAST_IDX) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state_r  <= S_IDLE;
          strobe_r <= 1'b1;
          last_r   <= 1'b1;
          case (act_r)
            lbm_pkg::ACT_LOOKUP, lbm_pkg::ACT_DIRTY: begin
              status_r  <= found_r ? lbm_pkg::ST_OK : lbm_pkg::ST_MISS;
              slot_r    <= found_r ? SLOT_W'(found_idx_r) : '0;
              wb_r      <= 1'b0;
              wb_slot_r <= '0;
              wb_blk_r  <= '0;
              if (found_r && act_r == lbm_pkg::ACT_DIRTY) begin
                dirty_r[found_idx_r] <= 1'b1;
              end
            end
            lbm_pkg::ACT_ALLOCATE: begin
              valid_r[victim] <= 1'b1;
              dirty_r[victim] <= 1'b0;
              status_r        <= lbm_pkg::ST_OK;
              slot_r          <= SLOT_W'(victim);
              wb_r            <= victim_wb;
              wb_slot_r       <= victim_wb ? SLOT_W'(victim) : '0;
              wb_blk_r        <= victim_wb ? best_blk_r : '0;
            end
            default: begin
              status_r  <= lbm_pkg::ST_OK;
              slot_r    <= pend_v_r ? SLOT_W'(pend_idx_r) : '0;
              wb_r      <= pend_v_r;
              wb_slot_r <= pend_v_r ? SLOT_W'(pend_idx_r) : '0;
              wb_blk_r  <= pend_v_r ? pend_blk_r : '0;
            end
          endcase
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_slot_index      = slot_r;
  assign out_writeback       = wb_r;
  assign out_writeback_slot  = wb_slot_r;
  assign out_writeback_block = wb_blk_r;
  assign out_last            = last_r;

endmodule

>>> rtl/core/lbm_checker.sv
// Port-level checks for the LRU block buffer manager, bound to its top level.
// Depends on lbm_pkg for the action and status codes.
module lbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [5:0]  out_slot_index,
  input logic        out_writeback,
  input logic [5:0]  out_writeback_slot,
  input logic [15:0] out_writeback_block
);

  // A flush always walks the slots, so it must raise busy.
  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == lbm_pkg::ACT_FLUSH |=> busy)
    else $error("flush item did not start a scan");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != lbm_pkg::ST_OK |-> out_slot_index == '0 && !out_writeback)
    else $error("error result carries a slot or writeback");

  a_wb_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_writeback |->
      out_status == lbm_pkg::ST_OK && out_writeback_slot == out_slot_index)
    else $error("writeback slot differs from result slot");

  a_no_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_writeback |-> out_writeback_slot == '0 && out_writeback_block == '0)
    else $error("writeback fields set without writeback");

endmodule

bind lru_block_buffer_manager lbm_checker u_lbm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_action           (in_action),
  .out_strobe          (out_strobe),
  .out_status          (out_status),
  .out_slot_index      (out_slot_index),
  .out_writeback       (out_writeback),
  .out_writeback_slot  (out_writeback_slot),
  .out_writeback_block (out_writeback_block)
);
